/* rtl/core/oscts_pkg.sv */
// Shared types and constants for the oscillator trim search block.
`timescale 1ns / 1ps
`default_nettype none

package oscts_pkg;

    localparam int unsigned LenW  = 14;
    localparam int unsigned TrimW = 8;
    localparam int unsigned StepW = 7;

    localparam logic [LenW-1:0]  DevInit     = 14'd9999;
    localparam logic [LenW-1:0]  DevMax      = 14'd16383;
    localparam logic [LenW-1:0]  TargetReset = 14'd1827;
    localparam logic [StepW-1:0] FirstStep   = 7'd64;
    localparam logic [TrimW-1:0] HighBase    = 8'd128;

    // One measurement item.
    typedef struct packed {
        logic            start_req;
        logic [LenW-1:0] measured_length;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [TrimW-1:0] trim_value;
        logic             done_res;
        logic [LenW-1:0]  best_deviation;
    } result_t;

    // Architectural state of the search.
    typedef struct packed {
        logic             busy;
        logic             region_high;
        logic [StepW-1:0] step_size;
        logic [TrimW-1:0] trial_trim;
        logic [TrimW-1:0] best_trim;
        logic [LenW-1:0]  best_dev;
    } search_t;

    // Status that the result queue reports to the input stage.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

/* rtl/core/oscillator_trim_search.sv */
// Top level of the oscillator trim search: input stage, search unit and result queue.
`timescale 1ns / 1ps
`default_nettype none

// The block calibrates an 8-bit oscillator trim by successive approximation against
// a measured frame length. A transfer with start_req set begins a search and returns
// trial 64; each later measurement moves the trial up when the length is below
// target_length and down otherwise, by a step that halves from 32 to 1, first over
// trims 1-127 and then over 129-255. The trial with the strictly smallest absolute
// deviation is kept, and after fourteen measurements the best trim comes back with
// done_res set. Measurements sent while no search runs return the best trim again.
// Every input transfer yields exactly one result transfer. The block accepts one
// item per cycle while item_stall is low. A taken item enters the input register,
// then passes through the search update, combinational logic between the input
// register and the two-entry result queue, into that queue. Input stall rises only
// when the input register holds an item and the queue holds two unread results.
// target_length must be written only while no item is in flight.

module oscillator_trim_search
    import oscts_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire logic [LenW-1:0] wr_data,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire item_t           item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output result_t              result
);

    logic [LenW-1:0] target_len_reg;
    item_t           item_reg;
    logic            item_valid_reg;
    logic            item_valid_next;
    logic            item_take;
    logic            stage_adv;
    queue_status_t   q_status;
    result_t         step_res;

    // The input register moves on whenever the queue has a free entry.
    assign stage_adv  = item_valid_reg && !q_status.full;
    assign item_stall = item_valid_reg && q_status.full;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item_take)
            item_valid_next = 1'b1;
        else if (stage_adv)
            item_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            target_len_reg <= TargetReset;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (wr_en)
                target_len_reg <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
    end

    // The search state updates exactly when its result enters the queue.
    oscts_search u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (stage_adv),
        .item_in (item_reg),
        .target  (target_len_reg),
        .res     (step_res)
    );

    oscts_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (stage_adv),
        .push_data (step_res),
        .status    (q_status),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (result)
    );

endmodule

`default_nettype wire

/* rtl/core/oscts_search.sv */
// Search state registers and the combinational update for one measurement.
`timescale 1ns / 1ps
`default_nettype none

module oscts_search
    import oscts_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire item_t           item_in,
    input  wire logic [LenW-1:0] target,
    output result_t              res
);

    search_t          st_reg;
    search_t          st_next;
    logic [LenW-1:0]  dev_raw;
    logic [LenW-1:0]  dev;
    logic [StepW-1:0] step_half;
    logic             below;

    always_comb
    begin
        below     = item_in.measured_length < target;
        dev_raw   = below ? (target - item_in.measured_length)
                          : (item_in.measured_length - target);
        dev       = (dev_raw > DevMax) ? DevMax : dev_raw;
        step_half = st_reg.step_size >> 1;
        st_next   = st_reg;
        res       = '0;

        if (item_in.start_req)
        begin
            st_next.busy        = 1'b1;
            st_next.region_high = 1'b0;
            st_next.step_size   = FirstStep;
            st_next.trial_trim  = {1'b0, FirstStep};
            st_next.best_trim   = '0;
            st_next.best_dev    = DevInit;
            res.trim_value      = {1'b0, FirstStep};
            res.done_res        = 1'b0;
        end
        else if (!st_reg.busy)
        begin
            res.trim_value = st_reg.best_trim;
            res.done_res   = 1'b1;
        end
        else
        begin
            if (dev < st_reg.best_dev)
            begin
                st_next.best_dev  = dev;
                st_next.best_trim = st_reg.trial_trim;
            end
            st_next.step_size = step_half;
            if (step_half == '0)
            begin
                if (!st_reg.region_high)
                begin
                    // Lower region exhausted: open the upper region.
                    st_next.region_high = 1'b1;
                    st_next.step_size   = FirstStep;
                    st_next.trial_trim  = HighBase + {1'b0, FirstStep};
                    res.trim_value      = HighBase + {1'b0, FirstStep};
                    res.done_res        = 1'b0;
                end
                else
                begin
                    st_next.busy   = 1'b0;
                    res.trim_value = st_next.best_trim;
                    res.done_res   = 1'b1;
                end
            end
            else
            begin
                if (below)
                    st_next.trial_trim = st_reg.trial_trim + {1'b0, step_half};
                else
                    st_next.trial_trim = st_reg.trial_trim - {1'b0, step_half};
                res.trim_value = st_next.trial_trim;
                res.done_res   = 1'b0;
            end
        end
        res.best_deviation = st_next.best_dev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{busy: 1'b0, region_high: 1'b0, step_size: '0,
                        trial_trim: '0, best_trim: '0, best_dev: DevInit};
        end
        else if (step_en)
        begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/oscts_outq.sv */
// Two-entry result queue that separates the search from the output stall.
`timescale 1ns / 1ps
`default_nettype none

module oscts_outq
    import oscts_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output queue_status_t status,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_data
);

    result_t    entry_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       pop;

    assign out_valid    = (count_reg != 2'd0);
    assign out_data     = entry_reg[rd_ptr_reg];
    assign pop          = out_valid && !out_stall;
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* rtl/core/oscts_checker.sv */
// Port-level checks for the oscillator trim search and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module oscts_checker
    import oscts_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            item_valid,
    input wire logic            item_stall,
    input wire item_t           item,
    input wire logic            result_valid,
    input wire logic            result_stall,
    input wire result_t         result
);

    // No result is offered while reset is applied.
    assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result offered during reset");

    // A stalled result transfer holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // A stalled input transfer stays offered with the same payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled input transfer changed");

    // The kept deviation never rises above its start value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.best_deviation <= DevInit)
        else $error("best deviation above start value");

    // Every trial offered during a search is a nonzero trim.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.done_res |-> result.trim_value != '0)
        else $error("zero trial trim during search");

endmodule

bind oscillator_trim_search oscts_checker u_oscts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

/* sim/oscillator_trim_search_tb.sv */
// Self-checking testbench for the oscillator trim search block.
`timescale 1ns / 1ps

// The testbench drives measurement transfers into the trim search and checks every
// result transfer against an in-bench model of the successive-approximation search.
// It starts with a short table of hand-picked transfers: idle reads after reset,
// lengths at both ends of the range, a search in which no deviation ever beats the
// initial value, a length equal to the target, and a restart in the middle of a
// running search. Then it sends random traffic in six segments, with the target
// length rewritten between segments, both ends of its range among the values.
// Most random traffic is well-formed: a start followed by fourteen measurements
// near the target. The rest is cut-short searches, idle reads and stray starts.
// The segments first idle the sender more lightly than the receiver, then the
// other way round, then run with no idling at all. Twice the receiver holds off
// for a long stretch, so that the block fills up and stalls its input.

module oscillator_trim_search_tb;
    import oscts_pkg::*;

    localparam int HoldCycles       = 60;
    localparam int RandomPerSegment = 310;
    localparam int Segments         = 6;
    localparam logic [LenW-1:0] LenMax = '1;

    // One row of the directed table. When has_res is set, res is the result that
    // the row must produce; otherwise the search model supplies it.
    typedef struct packed {
        item_t   stim;
        logic    has_res;
        result_t res;
    } stim_row_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            wr_en;
    logic [LenW-1:0] wr_data;
    logic            item_valid;
    logic            item_stall;
    item_t           item;
    logic            result_valid;
    logic            result_stall;
    result_t         result;

    // Model of the search: its own copy of the state and of the target length.
    search_t         srch;
    logic [LenW-1:0] model_target;

    // Results still owed by the block, oldest first.
    result_t         trim_expect_q[$];

    // Handoff from the sender to the monitor for rows with a typed-in result.
    bit              row_has_res;
    result_t         row_res;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;

    int n_errors       = 0;
    int n_items        = 0;
    int n_results      = 0;
    int n_searches     = 0;
    int n_input_stalls = 0;
    int n_targets      = 0;

    oscillator_trim_search u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_data      (wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    // Advances the search model by one transfer and returns the result that the
    // transfer must produce.
    function automatic result_t predict_trim(input item_t it);
        result_t         r;
        logic [LenW-1:0] dev;
        // A start wipes the best so far and proposes the first trial of the
        // low region, whatever the measurement says.
        if (it.start_req)
        begin
            srch.busy        = 1'b1;
            srch.region_high = 1'b0;
            srch.step_size   = FirstStep;
            srch.trial_trim  = {1'b0, FirstStep};
            srch.best_trim   = '0;
            srch.best_dev    = DevInit;
            r.trim_value     = srch.trial_trim;
            r.done_res       = 1'b0;
            r.best_deviation = srch.best_dev;
            return r;
        end
        // With no search running the block only repeats its best trim.
        if (!srch.busy)
        begin
            r.trim_value     = srch.best_trim;
            r.done_res       = 1'b1;
            r.best_deviation = srch.best_dev;
            return r;
        end
        dev = (it.measured_length >= model_target) ? it.measured_length - model_target
                                                   : model_target - it.measured_length;
        if (dev > DevMax)
            dev = DevMax;
        // Only a strictly smaller deviation replaces the best trial.
        if (dev < srch.best_dev)
        begin
            srch.best_dev  = dev;
            srch.best_trim = srch.trial_trim;
        end
        srch.step_size   = srch.step_size >> 1;
        r.best_deviation = srch.best_dev;
        if (srch.step_size == '0)
        begin
            if (!srch.region_high)
            begin
                // Low region exhausted: the high region opens at 128 + 64.
                srch.region_high = 1'b1;
                srch.step_size   = FirstStep;
                srch.trial_trim  = HighBase + {1'b0, FirstStep};
                r.trim_value     = srch.trial_trim;
                r.done_res       = 1'b0;
            end
            else
            begin
                srch.busy    = 1'b0;
                n_searches++;
                r.trim_value = srch.best_trim;
                r.done_res   = 1'b1;
            end
            return r;
        end
        // A short frame means a slow clock, so the trim goes up; wraps at 256.
        if (it.measured_length < model_target)
            srch.trial_trim = srch.trial_trim + {1'b0, srch.step_size};
        else
            srch.trial_trim = srch.trial_trim - {1'b0, srch.step_size};
        r.trim_value = srch.trial_trim;
        r.done_res   = 1'b0;
        return r;
    endfunction

    function automatic item_t make_item(input bit start, input logic [LenW-1:0] len);
        item_t it;
        it.start_req       = start;
        it.measured_length = len;
        return it;
    endfunction

    function automatic stim_row_t stim_row(input bit start, input logic [LenW-1:0] len,
                                           input bit has_res, input logic [TrimW-1:0] trim,
                                           input bit done, input logic [LenW-1:0] dev);
        stim_row_t r;
        r.stim               = make_item(start, len);
        r.has_res            = has_res;
        r.res.trim_value     = trim;
        r.res.done_res       = done;
        r.res.best_deviation = dev;
        return r;
    endfunction

    // Measured lengths: mostly close to the target so that the search really
    // converges and ties in deviation occur, plus the range ends and exact hits.
    function automatic logic [LenW-1:0] random_length();
        int v;
        int spread;
        case ($urandom_range(9))
            0: v = 0;
            1: v = LenMax;
            2: v = model_target;
            3, 4: v = $urandom_range(LenMax);
            default:
            begin
                case ($urandom_range(2))
                    0: spread = 3;
                    1: spread = 40;
                    default: spread = 700;
                endcase
                v = int'(model_target) + int'($urandom_range(2 * spread)) - spread;
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > LenMax)
            v = LenMax;
        return v[LenW-1:0];
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Offers one transfer, called and returning at a falling edge. Valid stays
    // high on return, so the next call either replaces the payload or drops
    // valid for a gap, never both in the same step.
    task automatic drive_item(input item_t it, input bit has_res, input result_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item        <= it;
        item_valid  <= 1'b1;
        row_has_res = has_res;
        row_res     = res;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drops valid and waits until every owed result has come back, plus some
    // margin, so that the block is idle.
    task automatic settle_pipeline();
        item_valid <= 1'b0;
        while (trim_expect_q.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_target(input logic [LenW-1:0] value);
        wr_en   <= 1'b1;
        wr_data <= value;
        @(negedge clk);
        wr_en        <= 1'b0;
        model_target = value;
        n_targets++;
    endtask

    // Random traffic: whole searches with random lengths, now and then a search
    // cut short by the next start, and between searches a few idle reads or a
    // stray start.
    task automatic send_search_traffic(input int n_wanted);
        int sent;
        int n_meas;
        int k;
        sent = 0;
        while (sent < n_wanted)
        begin
            drive_item(make_item(1'b1, random_length()), 1'b0, '0);
            n_meas = ($urandom_range(7) == 0) ? $urandom_range(13) : 14;
            for (k = 0; k < n_meas; k++)
                drive_item(make_item(1'b0, random_length()), 1'b0, '0);
            sent += n_meas + 1;
            k = $urandom_range(2);
            repeat (k)
                drive_item(make_item($urandom_range(11) == 0,
                                     LenW'($urandom_range(LenMax))),
                           1'b0, '0);
            sent += k;
        end
    endtask

    // Monitor: at each rising edge, an accepted input transfer queues what it
    // must produce, and an accepted result transfer is checked against the
    // oldest entry. Inputs change only at falling edges, so both sides are
    // stable here.
    always @(posedge clk)
    begin
        result_t predicted;
        result_t want;
        if (rst_n)
        begin
            if (item_valid && item_stall)
                n_input_stalls++;
            if (item_valid && !item_stall)
            begin
                predicted = predict_trim(item);
                trim_expect_q.push_back(row_has_res ? row_res : predicted);
                n_items++;
            end
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (trim_expect_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: extra result, expected none, got %0d/%0d/%0d",
                             $time, result.trim_value, result.done_res,
                             result.best_deviation);
                end
                else
                begin
                    want = trim_expect_q.pop_front();
                    check_field("trim_value", 32'(want.trim_value),
                                32'(result.trim_value));
                    check_field("done_res", 32'(want.done_res), 32'(result.done_res));
                    check_field("best_deviation", 32'(want.best_deviation),
                                32'(result.best_deviation));
                end
            end
        end
    end

    // Receiver: stalls at random at the current rate. On request it holds off for
    // a long counted stretch while the sender keeps offering transfers, which
    // fills the result queue and the input register.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HoldCycles)
                    @(negedge clk);
                hold_req = 1'b0;
                result_stall <= 1'b0;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        stim_row_t       rows[$];
        logic [LenW-1:0] seg_target;
        int              seg;

        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        wr_en       = 1'b0;
        wr_data     = '0;
        row_has_res = 1'b0;
        row_res     = '0;
        srch          = '0;
        srch.best_dev = DevInit;
        model_target  = TargetReset;

        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, run with the target at its reset value. After reset no
        // search has run, so idle reads give trim 0 and the initial deviation.
        rows.push_back(stim_row(1'b0, '0, 1'b1, '0, 1'b1, DevInit));
        rows.push_back(stim_row(1'b0, LenMax, 1'b1, '0, 1'b1, DevInit));
        // A start ignores its length and proposes the first trial.
        rows.push_back(stim_row(1'b1, LenMax, 1'b1, {1'b0, FirstStep}, 1'b0, DevInit));
        // A full search of maximum lengths: no deviation ever drops below the
        // initial value, so the trim reported at the end is 0.
        repeat (13)
            rows.push_back(stim_row(1'b0, LenMax, 1'b0, '0, 1'b0, '0));
        rows.push_back(stim_row(1'b0, LenMax, 1'b1, '0, 1'b1, DevInit));
        rows.push_back(stim_row(1'b0, '0, 1'b1, '0, 1'b1, DevInit));
        // A fresh search with an exact hit, then a restart in mid-search.
        rows.push_back(stim_row(1'b1, '0, 1'b1, {1'b0, FirstStep}, 1'b0, DevInit));
        rows.push_back(stim_row(1'b0, TargetReset, 1'b0, '0, 1'b0, '0));
        rows.push_back(stim_row(1'b0, '0, 1'b0, '0, 1'b0, '0));
        rows.push_back(stim_row(1'b1, LenMax, 1'b1, {1'b0, FirstStep}, 1'b0, DevInit));
        rows.push_back(stim_row(1'b0, '0, 1'b0, '0, 1'b0, '0));
        rows.push_back(stim_row(1'b0, TargetReset - 14'd1, 1'b0, '0, 1'b0, '0));
        foreach (rows[i])
            drive_item(rows[i].stim, rows[i].has_res, rows[i].res);
        settle_pipeline();

        // Random part. The target is rewritten only once the block is idle.
        for (seg = 0; seg < Segments; seg++)
        begin
            case (seg)
                0: seg_target = '0;
                1: seg_target = LenMax;
                3: seg_target = TargetReset;
                default: seg_target = LenW'($urandom_range(LenMax));
            endcase
            write_target(seg_target);
            send_idle_pct = (seg < 2) ? 24 : (seg < 4) ? 72 : 0;
            recv_idle_pct = (seg < 2) ? 72 : (seg < 4) ? 24 : 0;
            if (seg == 1 || seg == 4)
                hold_req = 1'b1;
            send_search_traffic(RandomPerSegment);
            settle_pipeline();
        end

        $display("Run covered %0d measurement transfers, %0d results, %0d searches done,",
                 n_items, n_results, n_searches);
        $display("%0d target settings, input stalled in %0d cycles, %0d mismatches.",
                 n_targets, n_input_stalls, n_errors);
        if (n_errors == 0)
            $display("[oscillator_trim_search] OK");
        else
            $display("[oscillator_trim_search] ERROR");
        $finish;
    end

    // Watchdog: the slowest correct run takes well under a tenth of this.
    initial
    begin
        #400000;
        $display("[oscillator_trim_search] ERROR");
        $finish;
    end

endmodule
